// ----- hdl/srit_pkg.sv -----
// Shared types and constants for the segment versus clip rectangle test.
package srit_pkg;

  // Outcode bits, y axis pointing down
  localparam logic [3:0] OC_TOP        = 4'h8;
  localparam logic [3:0] OC_BOTTOM     = 4'h4;
  localparam logic [3:0] OC_LEFT       = 4'h2;
  localparam logic [3:0] OC_RIGHT      = 4'h1;
  localparam logic [3:0] OC_STRADDLE_X = 4'h3;
  localparam logic [3:0] OC_STRADDLE_Y = 4'hC;

  // Configuration register indexes
  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_TOP    = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;
  localparam logic [1:0] REG_BOTTOM = 2'd3;

  typedef enum logic [2:0] {
    RULE_SHARED       = 3'd0,
    RULE_INSIDE       = 3'd1,
    RULE_STRADDLE     = 3'd2,
    RULE_SLOPE_REJECT = 3'd3,
    RULE_SLOPE_ACCEPT = 3'd4
  } rule_t;

endpackage

// ----- hdl/srit_seg_if.sv -----
// Segment channel: two endpoints per beat.
interface srit_seg_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] start_x;
  logic signed [W-1:0] start_y;
  logic signed [W-1:0] end_x;
  logic signed [W-1:0] end_y;

  modport source (output valid, output start_x, output start_y, output end_x,
                  output end_y, input ready);
  modport sink   (input valid, input start_x, input start_y, input end_x,
                  input end_y, output ready);
endinterface

// ----- hdl/srit_res_if.sv -----
// Result channel: hit flag and deciding rule per beat.
interface srit_res_if;
  logic       valid;
  logic       ready;
  logic       intersects;
  logic [2:0] decided_by;

  modport source (output valid, output intersects, output decided_by, input ready);
  modport sink   (input valid, input intersects, input decided_by, output ready);
endinterface

// ----- hdl/srit_outcode.sv -----
// Four-bit outcode of one point against the clip rectangle.
module srit_outcode #(
  parameter int W = 16
) (
  input  logic signed [W-1:0] x,
  input  logic signed [W-1:0] y,
  input  logic signed [W-1:0] clip_left,
  input  logic signed [W-1:0] clip_top,
  input  logic signed [W-1:0] clip_right,
  input  logic signed [W-1:0] clip_bottom,
  output logic [3:0]          code
);
  import srit_pkg::*;

  // an inverted rectangle may set both bits of an axis
  always_comb begin
    code = 4'h0;
    if (y < clip_top)    code = code | OC_TOP;
    if (y > clip_bottom) code = code | OC_BOTTOM;
    if (x < clip_left)   code = code | OC_LEFT;
    if (x > clip_right)  code = code | OC_RIGHT;
  end
endmodule

// ----- hdl/segment_rect_intersect_test.sv -----
// Top level: segment versus clip rectangle test, four register stages.
// Throughput: one segment per cycle; each stage loads when it is empty or the
// stage after it moves, so a stalled result still lets earlier stages fill.
// Reset (rst, synchronous): clears all stage valid bits and the clip registers to 0.
module segment_rect_intersect_test #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  srit_seg_if.sink               seg,
  srit_res_if.source             res,
  input  logic                   cfg_wen,
  input  logic [1:0]             cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data
);
  import srit_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int PW = 2 * W + 1;
  localparam int HW = 2 * W + 3;

  logic signed [W-1:0] clip_left, clip_top, clip_right, clip_bottom;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= '0;
      clip_top    <= '0;
      clip_right  <= '0;
      clip_bottom <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_LEFT:   clip_left   <= cfg_data;
        REG_TOP:    clip_top    <= cfg_data;
        REG_RIGHT:  clip_right  <= cfg_data;
        REG_BOTTOM: clip_bottom <= cfg_data;
      endcase
    end
  end

  // stage handshake: load when empty or the next stage takes the beat
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !v4 || res.ready;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign seg.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= seg.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // stage 1: outcodes, early rules, deltas
  logic [3:0] c0, c1, c_or;
  logic       shared, any_in, straddle;
  rule_t      early_rule;

  srit_outcode #(.W(W)) u_oc0 (
    .x(seg.start_x), .y(seg.start_y),
    .clip_left(clip_left), .clip_top(clip_top),
    .clip_right(clip_right), .clip_bottom(clip_bottom),
    .code(c0)
  );

  srit_outcode #(.W(W)) u_oc1 (
    .x(seg.end_x), .y(seg.end_y),
    .clip_left(clip_left), .clip_top(clip_top),
    .clip_right(clip_right), .clip_bottom(clip_bottom),
    .code(c1)
  );

  assign c_or     = c0 | c1;
  assign shared   = (c0 & c1) != 4'h0;
  assign any_in   = (c0 == 4'h0) || (c1 == 4'h0);
  assign straddle = (c_or == OC_STRADDLE_X) || (c_or == OC_STRADDLE_Y);

  always_comb begin
    priority if (shared) early_rule = RULE_SHARED;
    else if (any_in)     early_rule = RULE_INSIDE;
    else if (straddle)   early_rule = RULE_STRADDLE;
    else                 early_rule = RULE_SLOPE_ACCEPT;
  end

  logic signed [W-1:0]  s1_x0, s1_y0;
  logic signed [DW-1:0] s1_dx, s1_dy;
  logic                 s1_slope;
  rule_t                s1_rule;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_x0    <= seg.start_x;
      s1_y0    <= seg.start_y;
      s1_dx    <= DW'(seg.end_x) - DW'(seg.start_x);
      s1_dy    <= DW'(seg.end_y) - DW'(seg.start_y);
      s1_slope <= !shared && !any_in && !straddle;
      s1_rule  <= early_rule;
    end
  end

  // stage 2: products
  logic signed [PW-1:0] p_ydx, p_xdy, p_dl, p_dr, s2_bb, s2_tb;
  logic                 s2_neg, s2_slope;
  rule_t                s2_rule;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      p_ydx    <= s1_y0 * s1_dx;
      p_xdy    <= s1_x0 * s1_dy;
      p_dl     <= s1_dy * clip_left;
      p_dr     <= s1_dy * clip_right;
      s2_bb    <= clip_bottom * s1_dx;
      s2_tb    <= clip_top * s1_dx;
      s2_neg   <= s1_dx[DW-1];
      s2_slope <= s1_slope;
      s2_rule  <= s1_rule;
    end
  end

  // stage 3: line heights at the left and right edges
  logic signed [HW-1:0] s3_hl, s3_hr, s3_bb, s3_tb;
  logic                 s3_neg, s3_slope;
  rule_t                s3_rule;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_hl    <= HW'(p_dl) + HW'(p_ydx) - HW'(p_xdy);
      s3_hr    <= HW'(p_dr) + HW'(p_ydx) - HW'(p_xdy);
      s3_bb    <= HW'(s2_bb);
      s3_tb    <= HW'(s2_tb);
      s3_neg   <= s2_neg;
      s3_slope <= s2_slope;
      s3_rule  <= s2_rule;
    end
  end

  // stage 4: bound compares; a negative dx flips each compare instead of negating
  logic  reject;
  logic  hit_next;
  rule_t rule_next;

  always_comb begin
    if (s3_neg)
      reject = (s3_hl < s3_bb && s3_hr < s3_bb) || (s3_hl > s3_tb && s3_hr > s3_tb);
    else
      reject = (s3_hl > s3_bb && s3_hr > s3_bb) || (s3_hl < s3_tb && s3_hr < s3_tb);

    if (s3_slope) begin
      hit_next  = !reject;
      rule_next = reject ? RULE_SLOPE_REJECT : RULE_SLOPE_ACCEPT;
    end else begin
      hit_next  = (s3_rule != RULE_SHARED);
      rule_next = s3_rule;
    end
  end

  logic       intersects;
  logic [2:0] decided_by;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      intersects <= hit_next;
      decided_by <= rule_next;
    end
  end

  assign res.valid      = v4;
  assign res.intersects = intersects;
  assign res.decided_by = decided_by;

endmodule

// ----- hdl/srit_checker.sv -----
// Port-level checks for the segment versus clip rectangle test, with bind.
module srit_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic       intersects,
  input logic [2:0] decided_by
);
  import srit_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(intersects) && $stable(decided_by))
    else $error("result payload changed while stalled");

  a_rule_hit: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (intersects == (decided_by == RULE_INSIDE ||
                                  decided_by == RULE_STRADDLE ||
                                  decided_by == RULE_SLOPE_ACCEPT)) &&
                  (decided_by == RULE_SHARED || decided_by == RULE_INSIDE ||
                   decided_by == RULE_STRADDLE || decided_by == RULE_SLOPE_REJECT ||
                   decided_by == RULE_SLOPE_ACCEPT))
    else $error("hit flag disagrees with deciding rule");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind segment_rect_intersect_test srit_checker u_srit_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .intersects (res.intersects),
  .decided_by (res.decided_by)
);
